// ===== design/lph_pkg.sv =====
// Shared constants and codes for the linear probing hash table.
`timescale 1ns / 1ps
package lph_pkg;
    localparam int DEF_SLOTS        = 1024;
    localparam int DEF_PAYLOAD_BITS = 32;
    localparam int KEY_W            = 32;
    localparam int CMD_W            = 2;
    localparam int STATUS_W         = 2;
    localparam int ENTRY_W          = 11;
    localparam int PAYOUT_W         = 32;
    localparam int SLOT_ST_W        = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

    localparam logic [SLOT_ST_W-1:0] SLOT_FREE = 2'd0;
    localparam logic [SLOT_ST_W-1:0] SLOT_USED = 2'd1;
    localparam logic [SLOT_ST_W-1:0] SLOT_GONE = 2'd2;

    localparam logic [63:0] HASH_FLIP = 64'hC73AB174C5ECD5A2;
    localparam logic [31:0] MIX_LO    = 32'h1E98DF25;
    localparam logic [31:0] MIX_HI    = 32'h9FB21C65;
endpackage

// ===== design/lph_hash.sv =====
// Key hash to home slot on one shared 32x32 multiplier, with a folded remainder.
`timescale 1ns / 1ps
module lph_hash #(
    parameter int SLOTS = lph_pkg::DEF_SLOTS,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic [lph_pkg::KEY_W-1:0] key,
    output logic                     ready,
    output logic [IDX_W-1:0]         home
);
    import lph_pkg::*;

    localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int RECIP_SH = 31 + $clog2(SLOTS);
    localparam logic [63:0] FOLD_FULL  = (64'd1 << 32) % 64'(SLOTS);
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SH) / 64'(SLOTS);
    localparam logic [31:0] FOLD_C  = FOLD_FULL[31:0];
    localparam logic [31:0] RECIP_C = RECIP_FULL[31:0];
    localparam logic [31:0] SLOT_C  = 32'(SLOTS);

    localparam logic [2:0] H_IDLE  = 3'd0;
    localparam logic [2:0] H_MIX1  = 3'd1;
    localparam logic [2:0] H_FOLD  = 3'd2;
    localparam logic [2:0] H_MIX2  = 3'd3;
    localparam logic [2:0] H_FINAL = 3'd4;
    localparam logic [2:0] H_MOD   = 3'd5;
    localparam logic [2:0] H_QUOT  = 3'd6;
    localparam logic [2:0] H_SUB   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       sub_reg, sub_next;
    logic [63:0]      h_reg, h_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      p_reg, p_next;
    logic [IDX_W-1:0] home_reg, home_next;
    logic             ready_reg, ready_next;

    logic [63:0] x;
    logic [31:0] opa, opb;
    logic [63:0] prod;
    logic [63:0] quot;
    logic [31:0] diff;
    logic [31:0] rem;
    logic        hi_zero;

    assign x       = {key, key} ^ HASH_FLIP;
    assign prod    = {32'd0, opa} * {32'd0, opb};
    assign quot    = p_reg >> RECIP_SH;
    assign hi_zero = (h_reg[63:32] == 32'd0);
    assign diff    = h_reg[31:0] - p_reg[31:0];
    assign rem     = (diff >= SLOT_C) ? diff - SLOT_C : diff;

    always_comb
    begin
        opa = h_reg[31:0];
        opb = MIX_LO;
        if (state_reg == H_MOD)
        begin
            opa = hi_zero ? h_reg[31:0] : h_reg[63:32];
            opb = hi_zero ? RECIP_C : FOLD_C;
        end
        else if (state_reg == H_QUOT)
        begin
            opa = quot[31:0];
            opb = SLOT_C;
        end
        else
        begin
            unique case (sub_reg)
                2'd0:    begin opa = h_reg[31:0];  opb = MIX_LO; end
                2'd1:    begin opa = h_reg[63:32]; opb = MIX_LO; end
                default: begin opa = h_reg[31:0];  opb = MIX_HI; end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        h_next     = h_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        home_next  = home_reg;
        ready_next = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (go)
                begin
                    h_next     = x ^ {x[14:0], x[63:15]} ^ {x[39:0], x[63:40]};
                    acc_next   = '0;
                    sub_next   = '0;
                    state_next = H_MIX1;
                end
            end
            H_MIX1, H_MIX2:
            begin
                if (sub_reg != 2'd3)
                    p_next = prod;
                if (sub_reg == 2'd1)
                    acc_next = acc_reg + p_reg;
                else if (sub_reg != 2'd0)
                    acc_next = acc_reg + {p_reg[31:0], 32'd0};
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                    state_next = (state_reg == H_MIX1) ? H_FOLD : H_FINAL;
            end
            H_FOLD:
            begin
                h_next     = acc_reg ^ ((acc_reg >> 35) + 64'd4);
                acc_next   = '0;
                sub_next   = '0;
                state_next = H_MIX2;
            end
            H_FINAL:
            begin
                h_next     = acc_reg ^ (acc_reg >> 28);
                state_next = H_MOD;
            end
            H_MOD:
            begin
                if (POW2)
                begin
                    home_next  = h_reg[IDX_W-1:0];
                    ready_next = 1'b1;
                    state_next = H_IDLE;
                end
                else if (!hi_zero)
                    h_next = prod + {32'd0, h_reg[31:0]};
                else
                begin
                    p_next     = prod;
                    state_next = H_QUOT;
                end
            end
            H_QUOT:
            begin
                p_next     = prod;
                state_next = H_SUB;
            end
            H_SUB:
            begin
                home_next  = rem[IDX_W-1:0];
                ready_next = 1'b1;
                state_next = H_IDLE;
            end
            default:
                state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            ready_reg <= 1'b0;
            sub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        acc_reg  <= acc_next;
        p_reg    <= p_next;
        home_reg <= home_next;
    end

    assign ready = ready_reg;
    assign home  = home_reg;
endmodule

// ===== design/linear_probe_hash_table.sv =====
// Top level: slot memory, probe sequencer and result registers of the hash table.
`timescale 1ns / 1ps
// Usage:
//   A request is taken at a rising edge with start high and busy low; command,
//   key and payload are sampled there. busy stays high until the result.
//   Each request gives one result, shown for one cycle with done high on
//   status, payload_out and entry_count. The receiver cannot stall; the result
//   must be taken in that cycle.
//   Command three and an insert into a full table finish without the hash or
//   the probe. Otherwise the hash mixes the key, folds it and mixes it again,
//   then reduces it to a home slot, with a folded remainder when SLOTS is not a
//   power of two; then the probe reads one slot per cycle from the slot memory,
//   each slot's data arriving in the cycle after its read address.
//   busy falls with done, so a new request may be taken at the next edge.
//   Reset: after rst_n releases, a clearing pass marks every slot free, one slot
//   a cycle, with busy high; then requests are taken.
module linear_probe_hash_table #(
    parameter int SLOTS        = lph_pkg::DEF_SLOTS,
    parameter int PAYLOAD_BITS = lph_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lph_pkg::CMD_W-1:0]     command,
    input  logic [lph_pkg::KEY_W-1:0]     key,
    input  logic [PAYLOAD_BITS-1:0]       payload,
    output logic                          done,
    output logic [lph_pkg::STATUS_W-1:0]  status,
    output logic [lph_pkg::PAYOUT_W-1:0]  payload_out,
    output logic [lph_pkg::ENTRY_W-1:0]   entry_count
);
    import lph_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WORD_W = SLOT_ST_W + KEY_W + PAYLOAD_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]        ev_idx_reg, ev_idx_next;
    logic [IDX_W-1:0]        n_reg, n_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    done_reg, done_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [PAYOUT_W-1:0]     payout_reg, payout_next;
    logic                    eval_reg, eval_next;
    logic                    eval_ok;

    logic [WORD_W-1:0] mem [SLOTS];
    logic [WORD_W-1:0] mem_q;
    logic              we;
    logic [IDX_W-1:0]  wa;
    logic [WORD_W-1:0] wd;

    logic                    hash_go, hash_ready;
    logic [IDX_W-1:0]        hash_home;
    logic [SLOT_ST_W-1:0]    q_st;
    logic [KEY_W-1:0]        q_key;
    logic [PAYLOAD_BITS-1:0] q_pay;
    logic                    last;

    assign q_st  = mem_q[WORD_W-1 -: SLOT_ST_W];
    assign q_key = mem_q[PAYLOAD_BITS +: KEY_W];
    assign q_pay = mem_q[PAYLOAD_BITS-1:0];
    assign last  = (n_reg == IDX_W'(SLOTS - 1));

    lph_hash #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (hash_go),
        .key   (key_reg),
        .ready (hash_ready),
        .home  (hash_home)
    );

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        rd_idx_next = rd_idx_reg;
        ev_idx_next = ev_idx_reg;
        n_next      = n_reg;
        rd_vld_next = rd_vld_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        payout_next = payout_reg;
        hash_go     = 1'b0;
        we          = 1'b0;
        wa          = ev_idx_reg;
        wd          = {SLOT_USED, key_reg, pay_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                we          = 1'b1;
                wa          = rd_idx_reg;
                wd          = {SLOT_FREE, {(KEY_W + PAYLOAD_BITS){1'b0}}};
                rd_idx_next = (rd_idx_reg == IDX_W'(SLOTS - 1)) ? '0 : rd_idx_reg + 1'b1;
                if (rd_idx_reg == IDX_W'(SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    key_next = key;
                    pay_next = payload;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if ((cmd_reg != CMD_INSERT) && (cmd_reg != CMD_LOOKUP)
                    && (cmd_reg != CMD_REMOVE))
                begin
                    status_next = STAT_OK;
                    payout_next = '0;
                    state_next  = S_DONE;
                end
                else if ((cmd_reg == CMD_INSERT) && (count_reg == CNT_W'(SLOTS)))
                begin
                    status_next = STAT_FULL;
                    payout_next = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    hash_go     = 1'b1;
                    rd_vld_next = 1'b0;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (hash_ready)
                begin
                    rd_idx_next = hash_home;
                    n_next      = '0;
                    rd_vld_next = 1'b1;
                end
                else if (rd_vld_reg)
                begin
                    rd_idx_next = (rd_idx_reg == IDX_W'(SLOTS - 1)) ? '0 : rd_idx_reg + 1'b1;
                    ev_idx_next = rd_idx_reg;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (state_reg == S_PROBE && eval_ok)
        begin
            n_next      = n_reg + 1'b1;
            payout_next = '0;
            if (cmd_reg == CMD_INSERT)
            begin
                if (q_st != SLOT_USED)
                begin
                    we          = 1'b1;
                    wd          = {SLOT_USED, key_reg, pay_reg};
                    count_next  = count_reg + 1'b1;
                    status_next = STAT_OK;
                    state_next  = S_DONE;
                end
            end
            else if (q_st == SLOT_FREE)
            begin
                status_next = STAT_NOTFOUND;
                state_next  = S_DONE;
            end
            else if ((q_st == SLOT_USED) && (q_key == key_reg))
            begin
                status_next = STAT_OK;
                state_next  = S_DONE;
                if (cmd_reg == CMD_LOOKUP)
                    payout_next = PAYOUT_W'(q_pay);
                else
                begin
                    we         = 1'b1;
                    wd         = {SLOT_GONE, q_key, q_pay};
                    count_next = count_reg - 1'b1;
                end
            end
            else if (last)
            begin
                status_next = STAT_NOTFOUND;
                state_next  = S_DONE;
            end
        end
    end

    assign eval_next = (state_reg == S_PROBE) && rd_vld_reg && (state_next == S_PROBE);
    assign eval_ok   = eval_reg && (state_reg == S_PROBE);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        mem_q <= mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            eval_reg   <= 1'b0;
            n_reg      <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            rd_vld_reg <= rd_vld_next;
            eval_reg   <= eval_next;
            n_reg      <= n_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        ev_idx_reg <= ev_idx_next;
        status_reg <= status_next;
        payout_reg <= payout_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign payload_out = payout_reg;
    assign entry_count = ENTRY_W'(count_reg);
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the linear probing hash table.
`timescale 1ns / 1ps
module tb;
    import lph_pkg::*;

    localparam int SLOTS     = DEF_SLOTS;
    localparam int WDOG_MAX  = 20000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    class table_scoreboard;
        logic [SLOT_ST_W-1:0] st [SLOTS];
        logic [KEY_W-1:0]     keys [SLOTS];
        logic [31:0]          pays [SLOTS];
        int                   occupied;
        int                   errors;
        logic [STATUS_W-1:0]  exp_status [$];
        logic [PAYOUT_W-1:0]  exp_payload [$];
        logic [ENTRY_W-1:0]   exp_count [$];

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                st[i] = SLOT_FREE;
                keys[i] = '0;
                pays[i] = '0;
            end
            occupied = 0;
            errors = 0;
        endfunction

        function logic [63:0] rotl(logic [63:0] x, int r);
            return (x << r) | (x >> (64 - r));
        endfunction

        function int home_slot(logic [KEY_W-1:0] k);
            logic [63:0] h;
            logic [63:0] mul;
            mul = {MIX_HI, MIX_LO};
            h = {k, k} ^ HASH_FLIP;
            h = h ^ rotl(h, 49) ^ rotl(h, 24);
            h = h * mul;
            h = h ^ ((h >> 35) + 64'd4);
            h = h * mul;
            h = h ^ (h >> 28);
            return int'(h % SLOTS);
        endfunction

        function int find_slot(logic [KEY_W-1:0] k);
            int idx;
            idx = home_slot(k);
            for (int n = 0; n < SLOTS; n++)
            begin
                if (st[idx] == SLOT_FREE)
                    return -1;
                if (st[idx] == SLOT_USED && keys[idx] == k)
                    return idx;
                idx = (idx + 1) % SLOTS;
            end
            return -1;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                                   logic [31:0] p);
            logic [STATUS_W-1:0] s;
            logic [PAYOUT_W-1:0] po;
            int idx;
            s = STAT_OK;
            po = '0;
            if (cmd == CMD_INSERT)
            begin
                if (occupied >= SLOTS)
                    s = STAT_FULL;
                else
                begin
                    idx = home_slot(k);
                    while (st[idx] == SLOT_USED)
                        idx = (idx + 1) % SLOTS;
                    st[idx] = SLOT_USED;
                    keys[idx] = k;
                    pays[idx] = p;
                    occupied++;
                end
            end
            else if (cmd == CMD_LOOKUP)
            begin
                idx = find_slot(k);
                if (idx < 0)
                    s = STAT_NOTFOUND;
                else
                    po = pays[idx];
            end
            else if (cmd == CMD_REMOVE)
            begin
                idx = find_slot(k);
                if (idx < 0)
                    s = STAT_NOTFOUND;
                else
                begin
                    st[idx] = SLOT_GONE;
                    occupied--;
                end
            end
            exp_status.push_back(s);
            exp_payload.push_back(po);
            exp_count.push_back(ENTRY_W'(occupied));
        endfunction

        function void check_result(logic [STATUS_W-1:0] s, logic [PAYOUT_W-1:0] po,
                                   logic [ENTRY_W-1:0] c);
            logic [STATUS_W-1:0] es;
            logic [PAYOUT_W-1:0] ep;
            logic [ENTRY_W-1:0]  ec;
            if (exp_status.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d payload_out=%h entry_count=%0d",
                         $time, s, po, c);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            ep = exp_payload.pop_front();
            ec = exp_count.pop_front();
            if (s !== es)
            begin
                $display("%0t: status expected %0d actual %0d", $time, es, s);
                errors++;
            end
            if (po !== ep)
            begin
                $display("%0t: payload_out expected %h actual %h", $time, ep, po);
                errors++;
            end
            if (c !== ec)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time, ec, c);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [CMD_W-1:0]       command;
    logic [KEY_W-1:0]       key;
    logic [31:0]            payload;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [PAYOUT_W-1:0]    payload_out;
    logic [ENTRY_W-1:0]     entry_count;

    table_scoreboard sb;
    int              idle_pct;
    int              quiet_cycles;
    logic [KEY_W-1:0] key_pool [16];

    linear_probe_hash_table DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .key(key), .payload(payload),
        .done(done), .status(status), .payload_out(payload_out),
        .entry_count(entry_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(status, payload_out, entry_count);
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                                logic [31:0] p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        key     <= k;
        payload <= p;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(cmd, k, p);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.exp_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_mixed(int n);
        logic [KEY_W-1:0] k;
        logic [CMD_W-1:0] cmd;
        int r;
        for (int i = 0; i < n; i++)
        begin
            idle_pct = (i < n / 4) ? 0 : (i < n / 2) ? 64 : (i < 3 * n / 4) ? 6 : 0;
            k = ($urandom_range(3) == 0) ? $urandom() : key_pool[$urandom_range(15)];
            r = $urandom_range(99);
            cmd = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_LOOKUP : (r < 95) ? CMD_REMOVE
                : CMD_UNUSED;
            send_request(cmd, k, $urandom());
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_INSERT;
        key = '0;
        payload = '0;
        idle_pct = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_LOOKUP, 32'h0, 32'h0);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_LOOKUP, 32'h0, 32'h1234_5678);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_INSERT, 32'h0, 32'hA5A5_5A5A);
        send_request(CMD_LOOKUP, 32'h0, 32'h0);
        send_request(CMD_REMOVE, 32'h0, 32'h0);
        send_request(CMD_LOOKUP, 32'h0, 32'h0);
        send_request(CMD_REMOVE, 32'h0, 32'h0);
        send_request(CMD_REMOVE, 32'h0, 32'h0);
        send_request(CMD_LOOKUP, 32'h0, 32'h0);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h8000_0001, 32'h5555_AAAA);
        send_request(CMD_LOOKUP, 32'h8000_0001, 32'h0);
        send_request(CMD_LOOKUP, 32'h7FFF_FFFE, 32'h0);
        send_request(CMD_REMOVE, 32'h8000_0001, 32'h0);

        random_mixed(280);
        wait_drained();

        idle_pct = 0;
        while (sb.occupied < SLOTS)
            send_request(CMD_INSERT, $urandom(), $urandom());
        idle_pct = 6;
        for (int i = 0; i < 4; i++)
            send_request(CMD_INSERT, $urandom(), $urandom());
        for (int i = 0; i < 4; i++)
            send_request(CMD_LOOKUP, key_pool[i], 32'h0);
        send_request(CMD_LOOKUP, $urandom(), 32'h0);
        send_request(CMD_UNUSED, $urandom(), $urandom());
        for (int i = 0; i < 8; i++)
            send_request(CMD_REMOVE, sb.keys[$urandom_range(SLOTS - 1)], 32'h0);
        random_mixed(24);

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.exp_status.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
